// ===== rtl/esc_pkg.sv =====
// esc_pkg: shared types, constants and helpers for the sensor compensation unit
// used by esc_div and env_sensor_compensation_unit; no dependencies
package esc_pkg;

  // divider depth, one quotient bit per stage
  localparam int DivBits = 32;

  // register indexes on the configuration port
  localparam logic [2:0] RegTemp      = 3'd0;
  localparam logic [2:0] RegPressA    = 3'd1;
  localparam logic [2:0] RegPressB    = 3'd2;
  localparam logic [2:0] RegPressLast = 3'd3;
  localparam logic [2:0] RegHum       = 3'd4;

  // compensation constants
  localparam logic [31:0] HumOffset   = 32'd76800;
  localparam logic [31:0] HumClamp    = 32'd419430400;
  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] HumBias     = 32'd2097152;
  localparam logic [31:0] Half15      = 32'd32768;
  localparam logic [31:0] Round15     = 32'd16384;
  localparam logic [31:0] Round14     = 32'd8192;
  localparam logic [31:0] TempRound   = 32'd128;
  localparam logic [31:0] TempMul     = 32'd5;

  // side payload carried alongside the divider
  typedef struct packed {
    logic [15:0] tc;
    logic [31:0] hx;
    logic [31:0] hsq;
    logic        halve;
    logic        zero;
  } esc_side_t;

  // arithmetic right shift of a 32-bit pattern
  function automatic logic [31:0] asr(input logic [31:0] u, input logic [4:0] n);
    return $signed(u) >>> n;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

// ===== rtl/esc_div.sv =====
// esc_div: fully pipelined 32-bit unsigned restoring divider with side payload
// depends on esc_pkg
module esc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [31:0]       dividend,
  input  logic [31:0]       divisor,
  input  esc_pkg::esc_side_t side_in,
  output logic              out_valid,
  output logic [31:0]       quotient,
  output esc_pkg::esc_side_t side_out
);
  import esc_pkg::*;

  logic [31:0] rem_r [DivBits];
  logic [31:0] quo_r [DivBits];
  logic [31:0] dvd_r [DivBits];
  logic [31:0] dvs_r [DivBits];
  esc_side_t   side_r [DivBits];
  logic [DivBits-1:0] v_r;

  logic [31:0] rem_nxt [DivBits];
  logic [31:0] quo_nxt [DivBits];
  logic [31:0] dvd_nxt [DivBits];

  // one quotient bit per stage
  always_comb begin
    logic [31:0] prem, pquo, pdvd, pdvs;
    logic [32:0] trial, diff;
    for (int k = 0; k < DivBits; k++) begin
      if (k == 0) begin
        prem = '0;
        pquo = '0;
        pdvd = dividend;
        pdvs = divisor;
      end else begin
        prem = rem_r[k-1];
        pquo = quo_r[k-1];
        pdvd = dvd_r[k-1];
        pdvs = dvs_r[k-1];
      end
      trial = {prem, pdvd[31]};
      diff  = trial - {1'b0, pdvs};
      rem_nxt[k] = diff[32] ? trial[31:0] : diff[31:0];
      quo_nxt[k] = {pquo[30:0], ~diff[32]};
      dvd_nxt[k] = {pdvd[30:0], 1'b0};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < DivBits; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      dvd_r[k] <= dvd_nxt[k];
      dvs_r[k] <= (k == 0) ? divisor : dvs_r[k-1];
      side_r[k] <= (k == 0) ? side_in : side_r[k-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DivBits-2:0], in_valid};
    end
  end

  assign out_valid = v_r[DivBits-1];
  assign quotient  = quo_r[DivBits-1];
  assign side_out  = side_r[DivBits-1];

endmodule

// ===== rtl/env_sensor_compensation_unit.sv =====
// env_sensor_compensation_unit: top level of the sensor compensation pipeline
// depends on esc_pkg and esc_div
// path: front stages, then the divider, then the tail stages, to the result strobe
// throughput: one beat per cycle, busy is never raised; the 32-stage divider
// sets the depth, multipliers have a register stage after each one
// reset: synchronous, active low; clears valid bits and the configuration registers
module env_sensor_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  input  logic [15:0] in_raw_humidity,
  output logic        out_valid,
  output logic [15:0] out_temperature_centi,
  output logic [16:0] out_humidity_q10,
  output logic [31:0] out_pressure_pa,
  output logic        out_pressure_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import esc_pkg::*;

  // configuration registers
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_a_r, press_b_r, hum_r;
  logic [15:0] press_last_r;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_last_r  <= '0;
      hum_r         <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        RegTemp:      temp_coeffs_r <= pwdata[47:0];
        RegPressA:    press_a_r     <= pwdata;
        RegPressB:    press_b_r     <= pwdata;
        RegPressLast: press_last_r  <= pwdata[15:0];
        RegHum:       hum_r         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      RegTemp:      prdata = {16'd0, temp_coeffs_r};
      RegPressA:    prdata = press_a_r;
      RegPressB:    prdata = press_b_r;
      RegPressLast: prdata = {48'd0, press_last_r};
      RegHum:       prdata = hum_r;
      default:      prdata = '0;
    endcase
  end

  // coefficient fields
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_coeffs_r[15:0]};
  assign t2 = sx16(temp_coeffs_r[31:16]);
  assign t3 = sx16(temp_coeffs_r[47:32]);
  assign p1 = {16'd0, press_a_r[15:0]};
  assign p2 = sx16(press_a_r[31:16]);
  assign p3 = sx16(press_a_r[47:32]);
  assign p4 = sx16(press_a_r[63:48]);
  assign p5 = sx16(press_b_r[15:0]);
  assign p6 = sx16(press_b_r[31:16]);
  assign p7 = sx16(press_b_r[47:32]);
  assign p8 = sx16(press_b_r[63:48]);
  assign p9 = sx16(press_last_r);
  assign h1 = {24'd0, hum_r[7:0]};
  assign h2 = sx16(hum_r[23:8]);
  assign h3 = {24'd0, hum_r[31:24]};
  assign h4 = sx12(hum_r[43:32]);
  assign h5 = sx12(hum_r[55:44]);
  assign h6 = sx8(hum_r[63:56]);

  // valid bits of the front stages and the tail
  logic [7:0] v_r;
  logic [2:0] qv_r;
  logic       div_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      qv_r <= '0;
    end else begin
      v_r  <= {v_r[6:0], start};
      qv_r <= {qv_r[1:0], div_v};
    end
  end

  // stage 1: temperature products
  logic [31:0] s1_tm1_r, s1_tm2_r;
  logic [15:0] s1_hr_r;
  logic [19:0] s1_pr_r;
  logic [31:0] tx, tb;
  assign tx = {15'd0, in_raw_temperature[19:3]} - {t1[30:0], 1'b0};
  assign tb = {16'd0, in_raw_temperature[19:4]} - t1;

  always_ff @(posedge clk) begin
    s1_tm1_r <= tx * t2;
    s1_tm2_r <= tb * tb;
    s1_hr_r  <= in_raw_humidity;
    s1_pr_r  <= in_raw_pressure;
  end

  // stage 2
  logic [31:0] s2_ta_r, s2_tm3_r;
  logic [15:0] s2_hr_r;
  logic [19:0] s2_pr_r;
  always_ff @(posedge clk) begin
    s2_ta_r  <= asr(s1_tm1_r, 5'd11);
    s2_tm3_r <= asr(s1_tm2_r, 5'd12) * t3;
    s2_hr_r  <= s1_hr_r;
    s2_pr_r  <= s1_pr_r;
  end

  // stage 3: fine temperature
  logic [31:0] s3_tf_r;
  logic [15:0] s3_hr_r;
  logic [19:0] s3_pr_r;
  always_ff @(posedge clk) begin
    s3_tf_r <= s2_ta_r + asr(s2_tm3_r, 5'd14);
    s3_hr_r <= s2_hr_r;
    s3_pr_r <= s2_pr_r;
  end

  // stage 4: centi-degrees, first humidity and pressure products
  logic [31:0] tc, ha, pa, pb;
  logic [15:0] tc_sat;
  assign tc = asr(s3_tf_r * TempMul + TempRound, 5'd8);
  assign ha = s3_tf_r - HumOffset;
  assign pa = asr(s3_tf_r, 5'd1) - PressOffset;
  assign pb = asr(pa, 5'd2);

  always_comb begin
    if ($signed(tc) < -32'sd32768) begin
      tc_sat = 16'h8000;
    end else if ($signed(tc) > 32'sd32767) begin
      tc_sat = 16'h7fff;
    end else begin
      tc_sat = tc[15:0];
    end
  end

  logic [15:0] s4_tc_r, s4_hr_r;
  logic [19:0] s4_pr_r;
  logic [31:0] s4_hm1_r, s4_hm2_r, s4_hm3_r, s4_psq_r, s4_pm5_r, s4_pm2_r;
  always_ff @(posedge clk) begin
    s4_tc_r  <= tc_sat;
    s4_hr_r  <= s3_hr_r;
    s4_pr_r  <= s3_pr_r;
    s4_hm1_r <= h5 * ha;
    s4_hm2_r <= ha * h6;
    s4_hm3_r <= ha * h3;
    s4_psq_r <= pb * pb;
    s4_pm5_r <= pa * p5;
    s4_pm2_r <= p2 * pa;
  end

  // stage 5
  logic [31:0] hb, hc1, hc2;
  assign hb  = asr({2'd0, s4_hr_r, 14'd0} - {h4[11:0], 20'd0} - s4_hm1_r + Round15, 5'd15);
  assign hc1 = asr(s4_hm2_r, 5'd10);
  assign hc2 = asr(s4_hm3_r, 5'd11) + Half15;

  logic [15:0] s5_tc_r;
  logic [19:0] s5_pr_r;
  logic [31:0] s5_hb_r, s5_hmul_r, s5_pc_r, s5_pd_r, s5_pm5_r, s5_pm2_r;
  always_ff @(posedge clk) begin
    s5_tc_r   <= s4_tc_r;
    s5_pr_r   <= s4_pr_r;
    s5_hb_r   <= hb;
    s5_hmul_r <= hc1 * hc2;
    s5_pc_r   <= asr(s4_psq_r, 5'd11) * p6;
    s5_pd_r   <= p3 * asr(s4_psq_r, 5'd13);
    s5_pm5_r  <= s4_pm5_r;
    s5_pm2_r  <= s4_pm2_r;
  end

  // stage 6
  logic [31:0] hc3, pc2, pa2;
  assign hc3 = asr(s5_hmul_r, 5'd10) + HumBias;
  assign pc2 = asr(s5_pc_r + {s5_pm5_r[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'd0};
  assign pa2 = asr(asr(s5_pd_r, 5'd3) + asr(s5_pm2_r, 5'd1), 5'd18) + Half15;

  logic [15:0] s6_tc_r;
  logic [19:0] s6_pr_r;
  logic [31:0] s6_hb_r, s6_hm_r, s6_pc_r, s6_mp_r;
  always_ff @(posedge clk) begin
    s6_tc_r <= s5_tc_r;
    s6_pr_r <= s5_pr_r;
    s6_hb_r <= s5_hb_r;
    s6_hm_r <= hc3 * h2;
    s6_pc_r <= pc2;
    s6_mp_r <= pa2 * p1;
  end

  // stage 7
  logic [31:0] hc4, pnum;
  assign hc4  = asr(s6_hm_r + Round14, 5'd14);
  assign pnum = PressBase - {12'd0, s6_pr_r} - asr(s6_pc_r, 5'd12);

  logic [15:0] s7_tc_r;
  logic [31:0] s7_hx_r, s7_pm_r, s7_dvs_r;
  always_ff @(posedge clk) begin
    s7_tc_r  <= s6_tc_r;
    s7_hx_r  <= s6_hb_r * hc4;
    s7_pm_r  <= pnum * PressScale;
    s7_dvs_r <= asr(s6_mp_r, 5'd15);
  end

  // stage 8: operands for the divider
  logic [31:0] hbs;
  assign hbs = asr(s7_hx_r, 5'd15);

  esc_side_t   s8_side_r;
  logic [31:0] s8_dvd_r, s8_dvs_r;
  always_ff @(posedge clk) begin
    s8_side_r.tc    <= s7_tc_r;
    s8_side_r.hx    <= s7_hx_r;
    s8_side_r.hsq   <= hbs * hbs;
    s8_side_r.halve <= s7_pm_r[31];
    s8_side_r.zero  <= (s7_dvs_r == '0);
    s8_dvd_r        <= s7_pm_r[31] ? s7_pm_r : {s7_pm_r[30:0], 1'b0};
    s8_dvs_r        <= s7_dvs_r;
  end

  logic [31:0] div_q;
  esc_side_t   div_side;

  esc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[7]),
    .dividend  (s8_dvd_r),
    .divisor   (s8_dvs_r),
    .side_in   (s8_side_r),
    .out_valid (div_v),
    .quotient  (div_q),
    .side_out  (div_side)
  );

  // tail stage 1: pressure correction products, humidity square term
  logic [31:0] pq;
  assign pq = div_side.halve ? {div_q[30:0], 1'b0} : div_q;

  logic [31:0] q1_p_r, q1_qsq_r, q1_pf_r, q1_hcc_r, q1_hx_r;
  logic [15:0] q1_tc_r;
  logic        q1_zero_r;
  always_ff @(posedge clk) begin
    q1_p_r    <= pq;
    q1_qsq_r  <= {3'd0, pq[31:3]} * {3'd0, pq[31:3]};
    q1_pf_r   <= {2'd0, pq[31:2]} * p8;
    q1_hcc_r  <= asr(div_side.hsq, 5'd7) * h1;
    q1_hx_r   <= div_side.hx;
    q1_tc_r   <= div_side.tc;
    q1_zero_r <= div_side.zero;
  end

  // tail stage 2: humidity clamp, last pressure product
  logic [31:0] hfin, hcl;
  assign hfin = q1_hx_r - asr(q1_hcc_r, 5'd4);
  always_comb begin
    if (hfin[31]) begin
      hcl = '0;
    end else if (hfin > HumClamp) begin
      hcl = HumClamp;
    end else begin
      hcl = hfin;
    end
  end

  logic [31:0] q2_p_r, q2_e_r, q2_f_r;
  logic [16:0] q2_hq_r;
  logic [15:0] q2_tc_r;
  logic        q2_zero_r;
  always_ff @(posedge clk) begin
    q2_p_r    <= q1_p_r;
    q2_e_r    <= p9 * {13'd0, q1_qsq_r[31:13]};
    q2_f_r    <= asr(q1_pf_r, 5'd13);
    q2_hq_r   <= hcl[28:12];
    q2_tc_r   <= q1_tc_r;
    q2_zero_r <= q1_zero_r;
  end

  // tail stage 3: result beat
  logic [31:0] pfin;
  assign pfin = q2_p_r + asr(asr(q2_e_r, 5'd12) + q2_f_r + p7, 5'd4);

  logic [15:0] t_out_r;
  logic [16:0] h_out_r;
  logic [31:0] p_out_r;
  logic        pv_out_r;
  always_ff @(posedge clk) begin
    t_out_r  <= q2_tc_r;
    h_out_r  <= q2_hq_r;
    p_out_r  <= q2_zero_r ? '0 : pfin;
    pv_out_r <= ~q2_zero_r;
  end

  assign out_valid             = qv_r[2];
  assign out_temperature_centi = t_out_r;
  assign out_humidity_q10      = h_out_r;
  assign out_pressure_pa       = p_out_r;
  assign out_pressure_valid    = pv_out_r;

endmodule

// ===== tb/env_sensor_compensation_unit_test.sv =====
// env_sensor_compensation_unit_test: self-checking bench for the sensor compensation unit
// drives raw readings and calibration writes, predicts every compensated beat in-line
// depends on esc_pkg and env_sensor_compensation_unit
module env_sensor_compensation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic [15:0] temperature_centi;
    logic [16:0] humidity_q10;
    logic [31:0] pressure_pa;
    logic        pressure_valid;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic [15:0] in_raw_humidity = '0;
  logic        out_valid;
  logic [15:0] out_temperature_centi;
  logic [16:0] out_humidity_q10;
  logic [31:0] out_pressure_pa;
  logic        out_pressure_valid;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // calibration as the bench believes it to be
  logic [47:0] cal_temp = '0;
  logic [63:0] cal_press_a = '0;
  logic [63:0] cal_press_b = '0;
  logic [15:0] cal_p9 = '0;
  logic [63:0] cal_hum = '0;

  reading_t pending_readings[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       idling_on = 1'b1;

  env_sensor_compensation_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_raw_temperature   (in_raw_temperature),
    .in_raw_pressure      (in_raw_pressure),
    .in_raw_humidity      (in_raw_humidity),
    .out_valid            (out_valid),
    .out_temperature_centi(out_temperature_centi),
    .out_humidity_q10     (out_humidity_q10),
    .out_pressure_pa      (out_pressure_pa),
    .out_pressure_valid   (out_pressure_valid),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  // compensation of one raw reading with the current calibration
  function automatic reading_t compensate(input logic [19:0] traw, input logic [19:0] praw,
                                          input logic [15:0] hraw);
    reading_t    r;
    logic [31:0] tr, pr, hr, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, a, b, c, tf, tc, q, e, f, p;
    tr = {12'b0, traw};
    pr = {12'b0, praw};
    hr = {16'b0, hraw};
    t1 = {16'b0, cal_temp[15:0]};
    t2 = 32'($signed(cal_temp[31:16]));
    t3 = 32'($signed(cal_temp[47:32]));
    p1 = {16'b0, cal_press_a[15:0]};
    p2 = 32'($signed(cal_press_a[31:16]));
    p3 = 32'($signed(cal_press_a[47:32]));
    p4 = 32'($signed(cal_press_a[63:48]));
    p5 = 32'($signed(cal_press_b[15:0]));
    p6 = 32'($signed(cal_press_b[31:16]));
    p7 = 32'($signed(cal_press_b[47:32]));
    p8 = 32'($signed(cal_press_b[63:48]));
    p9 = 32'($signed(cal_p9));
    h1 = {24'b0, cal_hum[7:0]};
    h2 = 32'($signed(cal_hum[23:8]));
    h3 = {24'b0, cal_hum[31:24]};
    h4 = 32'($signed(cal_hum[43:32]));
    h5 = 32'($signed(cal_hum[55:44]));
    h6 = 32'($signed(cal_hum[63:56]));

    // fine temperature and saturated centidegrees
    a = (tr >> 3) - (t1 << 1);
    a = shr_s(a * t2, 11);
    b = (tr >> 4) - t1;
    c = shr_s(b * b, 12);
    c = shr_s(c * t3, 14);
    tf = a + c;
    tc = shr_s(tf * 32'd5 + 32'd128, 8);
    if ($signed(tc) < -32768) r.temperature_centi = 16'h8000;
    else if ($signed(tc) > 32767) r.temperature_centi = 16'h7fff;
    else r.temperature_centi = tc[15:0];

    // humidity, clamped before the final shift
    a = tf - 32'd76800;
    b = shr_s((hr << 14) - (h4 << 20) - h5 * a + 32'd16384, 15);
    c = shr_s(a * h6, 10);
    c = c * (shr_s(a * h3, 11) + 32'd32768);
    c = shr_s(c, 10) + 32'd2097152;
    c = shr_s(c * h2 + 32'd8192, 14);
    a = b * c;
    b = shr_s(a, 15);
    c = shr_s(b * b, 7);
    c = shr_s(c * h1, 4);
    a = a - c;
    if (a[31]) a = '0;
    else if (a > 32'd419430400) a = 32'd419430400;
    r.humidity_q10 = 17'(a >> 12);

    // pressure, zero divisor gives an invalid reading
    a = shr_s(tf, 1) - 32'd64000;
    b = shr_s(a, 2);
    c = shr_s(b * b, 11) * p6;
    c = c + ((a * p5) << 1);
    c = shr_s(c, 2) + (p4 << 16);
    q = shr_s(b * b, 13);
    a = shr_s(shr_s(p3 * q, 3) + shr_s(p2 * a, 1), 18);
    a = shr_s((a + 32'd32768) * p1, 15);
    if (a == 0) begin
      r.pressure_pa = '0;
      r.pressure_valid = 1'b0;
    end else begin
      p = (32'd1048576 - pr - shr_s(c, 12)) * 32'd3125;
      if (!p[31]) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      q = p >> 3;
      e = shr_s(p9 * ((q * q) >> 13), 12);
      f = shr_s((p >> 2) * p8, 13);
      p = p + shr_s(e + f + p7, 4);
      r.pressure_pa = p;
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_temperature_centi, out_humidity_q10, out_pressure_pa, out_pressure_valid};
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: temp %0d hum %0d press %0d valid %0b",
                   $signed(got.temperature_centi), got.humidity_q10, got.pressure_pa,
                   got.pressure_valid);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: temp %0d/%0d hum %0d/%0d press %0d/%0d valid %0b/%0b",
                     $signed(want.temperature_centi), $signed(got.temperature_centi),
                     want.humidity_q10, got.humidity_q10, want.pressure_pa,
                     got.pressure_pa, want.pressure_valid, got.pressure_valid);
        end
      end
    end
  end

  // one register write, setup then access
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegTemp:      cal_temp = val[47:0];
      RegPressA:    cal_press_a = val;
      RegPressB:    cal_press_b = val;
      RegPressLast: cal_p9 = val[15:0];
      RegHum:       cal_hum = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(input logic [47:0] t, input logic [63:0] pa, input logic [63:0] pb,
                           input logic [15:0] p9, input logic [63:0] h);
    write_reg(RegTemp, {16'b0, t});
    write_reg(RegPressA, pa);
    write_reg(RegPressB, pb);
    write_reg(RegPressLast, {48'b0, p9});
    write_reg(RegHum, h);
  endtask

  // typical factory calibration
  task automatic load_typical_cal();
    write_all({-16'sd1000, 16'sd26435, 16'd27504},
              {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
              {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
              16'sd6000,
              {8'sd30, 12'sd50, 12'sd313, 8'd0, 16'sd362, 8'd75});
  endtask

  // wait until every expected beat is back, plus a short settle
  task automatic drain();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // send one raw reading; start stays high into the next beat
  task automatic send_reading(input logic [19:0] traw, input logic [19:0] praw,
                              input logic [15:0] hraw);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_raw_temperature <= traw;
    in_raw_pressure <= praw;
    in_raw_humidity <= hraw;
    do @(posedge clk); while (busy);
    pending_readings.push_back(compensate(traw, praw, hraw));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_reading(20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  // reset calibration: zero divisor on every beat
  task automatic test_zero_divisor();
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    send_reading(20'h80000, 20'h7ffff, 16'h8000);
    stop_sending();
    drain();
  endtask

  // field extremes with a realistic calibration
  task automatic test_extremes();
    load_typical_cal();
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    send_reading(20'd519888, 20'd415148, 16'd32768);
    send_reading(20'h00001, 20'hfffff, 16'h0000);
    send_reading(20'hfffff, 20'h00000, 16'hffff);
    stop_sending();
    drain();
  endtask

  // temperature saturation on both sides
  task automatic test_temp_saturation();
    write_reg(RegTemp, {16'b0, 16'sd0, 16'sd32767, 16'd0});
    send_reading('1, 20'd400000, 16'd30000);
    stop_sending();
    drain();
    write_reg(RegTemp, {16'b0, 16'sd0, -16'sd32768, 16'd0});
    send_reading('1, 20'd400000, 16'd30000);
    stop_sending();
    drain();
  endtask

  // humidity clamp at both ends, register extremes
  task automatic test_humidity_clamp();
    load_typical_cal();
    write_reg(RegHum, {8'sd127, 12'sd0, -12'sd2048, 8'd255, 16'sd32767, 8'd0});
    send_reading(20'd519888, 20'd415148, 16'hffff);
    stop_sending();
    drain();
    write_reg(RegHum, {8'sd0, 12'sd0, 12'sd2047, 8'd0, 16'sd32767, 8'd0});
    send_reading(20'd519888, 20'd415148, 16'h0000);
    stop_sending();
    drain();
    write_all('1, '1, '1, '1, '1);
    send_reading(20'd519888, 20'd415148, 16'h1234);
    send_reading('1, '1, '1);
    stop_sending();
    drain();
  endtask

  // random readings over typical and random calibrations
  task automatic test_random_readings();
    load_typical_cal();
    send_random(150);
    stop_sending();
    drain();
    repeat (3) begin
      write_all(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                16'($urandom), {$urandom, $urandom});
      send_random(80);
      stop_sending();
      drain();
    end
    // typical coefficients with a random last pressure coefficient
    load_typical_cal();
    write_reg(RegPressLast, 64'(16'($urandom)));
    send_random(60);
    // no idling over the closing stretch
    idling_on = 1'b0;
    send_random(60);
    stop_sending();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_zero_divisor();
    test_extremes();
    test_temp_saturation();
    test_humidity_clamp();
    test_random_readings();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
